// ----- src/grce_pkg.sv -----
// ----------------------------------------------------------------------------
// grce_pkg: shared types for glyph row colour expansion
// Item structs, register and depth codes, state codes and depth helpers.
// ----------------------------------------------------------------------------
package grce_pkg;

    localparam int GRCE_MAX_GLYPH_WIDTH = 32;
    localparam int GRCE_LANE_W          = 8;
    localparam int GRCE_BITMAP_W        = 32;

    typedef enum logic [1:0] {
        CFG_FB_BASE     = 2'd0,
        CFG_LINE_PITCH  = 2'd1,
        CFG_DEPTH_MODE  = 2'd2,
        CFG_GLYPH_WIDTH = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DEPTH_8  = 2'd0,
        DEPTH_16 = 2'd1,
        DEPTH_24 = 2'd2,
        DEPTH_32 = 2'd3
    } depth_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LINE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [31:0] glyph_bits;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [4:0]  row_index;
        logic [31:0] colour;
    } in_item_t;

    typedef struct packed {
        logic [31:0] write_address;
        logic [31:0] write_data;
        logic [3:0]  byte_enable;
        logic        last_write;
    } out_item_t;

    function automatic logic [3:0] depth_enables(depth_t d);
        logic [3:0] be;
        unique case (d)
            DEPTH_8:  be = 4'b0001;
            DEPTH_16: be = 4'b0011;
            DEPTH_24: be = 4'b0111;
            default:  be = 4'b1111;
        endcase
        return be;
    endfunction

    function automatic logic [31:0] depth_mask(depth_t d);
        logic [31:0] m;
        unique case (d)
            DEPTH_8:  m = 32'h0000_00ff;
            DEPTH_16: m = 32'h0000_ffff;
            DEPTH_24: m = 32'h00ff_ffff;
            default:  m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    // byte offset of pixel x within a scanline
    function automatic logic [17:0] pixel_offset(depth_t d, logic [15:0] x);
        logic [17:0] off;
        unique case (d)
            DEPTH_8:  off = {2'b00, x};
            DEPTH_16: off = {1'b0, x, 1'b0};
            DEPTH_24: off = {1'b0, x, 1'b0} + {2'b00, x};
            default:  off = {x, 2'b00};
        endcase
        return off;
    endfunction

endpackage

// ----- src/grce_lane.sv -----
// ----------------------------------------------------------------------------
// grce_lane: priority search over one segment of columns
// Finds the lowest pending column in its segment.
// ----------------------------------------------------------------------------
module grce_lane #(
    parameter int LANE_W = 8
) (
    input  logic [LANE_W-1:0]         seg,
    output logic                      hit,
    output logic [$clog2(LANE_W)-1:0] idx
);

    always_comb
    begin
        hit = |seg;
        idx = '0;
        for (int i = LANE_W - 1; i >= 0; i--)
        begin
            if (seg[i])
            begin
                idx = ($clog2(LANE_W))'(i);
            end
        end
    end

endmodule

// ----- src/grce_pick.sv -----
// ----------------------------------------------------------------------------
// grce_pick: next column selection
// Lanes search their segments side by side; the merge takes the lowest lane.
// ----------------------------------------------------------------------------
module grce_pick #(
    parameter int PAD_W  = 32,
    parameter int LANE_W = 8
) (
    input  logic [PAD_W-1:0]         mask,
    output logic                     hit,
    output logic [$clog2(PAD_W)-1:0] col
);

    localparam int NUM_LANES = PAD_W / LANE_W;
    localparam int IDX_W     = $clog2(LANE_W);
    localparam int COL_W     = $clog2(PAD_W);

    logic [NUM_LANES-1:0] lane_hit;
    logic [IDX_W-1:0]     lane_idx [NUM_LANES];

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        grce_lane #(
            .LANE_W(LANE_W)
        ) u_lane (
            .seg(mask[l*LANE_W +: LANE_W]),
            .hit(lane_hit[l]),
            .idx(lane_idx[l])
        );
    end

    // lowest lane with a pending column wins
    always_comb
    begin
        hit = |lane_hit;
        col = '0;
        for (int l = NUM_LANES - 1; l >= 0; l--)
        begin
            if (lane_hit[l])
            begin
                col = COL_W'(l * LANE_W) | COL_W'(lane_idx[l]);
            end
        end
    end

endmodule

// ----- src/glyph_row_colour_expand.sv -----
// ----------------------------------------------------------------------------
// glyph_row_colour_expand: monochrome colour expansion of one glyph row
// Turns each set bit of a glyph row bitmap into one framebuffer write.
// ----------------------------------------------------------------------------
// Usage
//   in channel (in_valid/in_ready/in_item): one glyph row per transfer, with
//   bitmap, screen position, row index and packed colour.
//   out channel (out_valid/out_ready/out_item): one framebuffer write per set
//   bit, leftmost column first; last_write marks the final write of a row.
//   cfg port (cfg_we/cfg_index/cfg_data): base, pitch, depth and glyph width,
//   written only while no row is in flight, a rule the block leaves to the user.
// Timing
//   a row passes the scanline multiply in ST_LINE, then the column search over
//   the pending-column mask gives one write per cycle while the receiver keeps
//   out_ready high; an empty row goes from ST_LINE straight back to idle.
//   The first write enters the output register in ST_EMIT, after ST_LINE.
//   One row is worked at a time; in_ready is high while no row is pending,
//   even while the last write still waits in the output register.
// Reset and stall
//   reset loads the register defaults and empties the output register.
//   A stalled receiver holds the write in the output register and the column
//   search waits.
// ----------------------------------------------------------------------------
module glyph_row_colour_expand #(
    parameter int MAX_GLYPH_WIDTH = grce_pkg::GRCE_MAX_GLYPH_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  grce_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output grce_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  grce_pkg::cfg_reg_t  cfg_index,
    input  logic [31:0]         cfg_data
);

    import grce_pkg::*;

    localparam int NUM_LANES = (MAX_GLYPH_WIDTH + GRCE_LANE_W - 1) / GRCE_LANE_W;
    localparam int PAD_W     = NUM_LANES * GRCE_LANE_W;
    localparam int COL_W     = $clog2(PAD_W);
    localparam int SHIFT_W   = $clog2(MAX_GLYPH_WIDTH + 1);
    localparam int SRC_W     = (MAX_GLYPH_WIDTH < GRCE_BITMAP_W) ?
                               MAX_GLYPH_WIDTH : GRCE_BITMAP_W;

    // configuration
    logic [31:0] fb_base_reg;
    logic [15:0] line_pitch_reg;
    depth_t      depth_reg;
    logic [5:0]  glyph_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_base_reg     <= 32'd0;
            line_pitch_reg  <= 16'd4096;
            depth_reg       <= DEPTH_32;
            glyph_width_reg <= 6'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FB_BASE:     fb_base_reg     <= cfg_data;
                CFG_LINE_PITCH:  line_pitch_reg  <= cfg_data[15:0];
                CFG_DEPTH_MODE:  depth_reg       <= depth_t'(cfg_data[1:0]);
                CFG_GLYPH_WIDTH: glyph_width_reg <= cfg_data[5:0];
                default:         ;
            endcase
        end
    end

    // control and datapath registers
    state_t              state_reg, state_next;
    logic [PAD_W-1:0]    mask_reg;
    logic [15:0]         px_reg;
    logic [15:0]         y_reg;
    logic [31:0]         data_reg;
    logic [31:0]         line_addr_reg;
    logic                out_valid_reg;
    out_item_t           out_item_reg;

    logic                in_xfer;
    logic                load;
    logic                pick_hit;
    logic [COL_W-1:0]    pick_col;
    logic [PAD_W-1:0]    mask_clr;
    logic [PAD_W-1:0]    colmask;
    logic [MAX_GLYPH_WIDTH-1:0] bits_ext;
    logic [MAX_GLYPH_WIDTH-1:0] bits_rev;
    logic [SHIFT_W-1:0]  width_sat;
    logic [SHIFT_W-1:0]  shift_amt;
    logic [15:0]         pix_x;
    logic [31:0]         line_prod;

    // column c reads bitmap bit width-1-c: reverse, then align to column 0
    always_comb
    begin
        bits_ext = '0;
        for (int i = 0; i < SRC_W; i++)
        begin
            bits_ext[i] = in_item.glyph_bits[i];
        end
        for (int i = 0; i < MAX_GLYPH_WIDTH; i++)
        begin
            bits_rev[i] = bits_ext[MAX_GLYPH_WIDTH-1-i];
        end
        if (int'(glyph_width_reg) > MAX_GLYPH_WIDTH)
        begin
            width_sat = SHIFT_W'(MAX_GLYPH_WIDTH);
        end
        else
        begin
            width_sat = SHIFT_W'(glyph_width_reg);
        end
        shift_amt = SHIFT_W'(MAX_GLYPH_WIDTH) - width_sat;
        colmask   = PAD_W'(bits_rev >> shift_amt);
    end

    grce_pick #(
        .PAD_W (PAD_W),
        .LANE_W(GRCE_LANE_W)
    ) u_pick (
        .mask(mask_reg),
        .hit (pick_hit),
        .col (pick_col)
    );

    assign mask_clr  = mask_reg & (mask_reg - 1'b1);
    assign pix_x     = px_reg + 16'(pick_col);
    assign line_prod = {16'd0, line_pitch_reg} * {16'd0, y_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LINE;
                end
            end
            ST_LINE:
            begin
                state_next = (mask_reg == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load && mask_clr == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_LINE: ;
            ST_EMIT: load = pick_hit && (!out_valid_reg || out_ready);
            default: ;
        endcase
    end

    assign in_xfer = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                mask_reg <= colmask;
            end
            else if (load)
            begin
                mask_reg <= mask_clr;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg   <= in_item.pos_x;
            y_reg    <= in_item.pos_y + 16'(in_item.row_index);
            data_reg <= in_item.colour & depth_mask(depth_reg);
        end
        if (state_reg == ST_LINE)
        begin
            line_addr_reg <= fb_base_reg + line_prod;
        end
        if (load)
        begin
            out_item_reg.write_address <= line_addr_reg
                                          + 32'(pixel_offset(depth_reg, pix_x));
            out_item_reg.write_data    <= data_reg;
            out_item_reg.byte_enable   <= depth_enables(depth_reg);
            out_item_reg.last_write    <= (mask_clr == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- src/grce_checker.sv -----
// ----------------------------------------------------------------------------
// grce_checker: port-level checks for glyph row colour expansion
// Watches the channels of the top level and flags ordering slips.
// ----------------------------------------------------------------------------
module grce_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input grce_pkg::out_item_t out_item
);

    import grce_pkg::*;

    // a stalled write stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("write dropped while stalled");

    // a stalled write keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_item))
        else $error("write payload changed while stalled");

    // one row at a time: no new row right after a row transfer
    a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("row accepted while previous row pending");

    // the next write of the row is offered as soon as a non-final write is taken
    a_row_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_item.last_write |=> out_valid)
        else $error("gap after a non-final write of a row");

endmodule

bind glyph_row_colour_expand grce_checker u_grce_checker (.*);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: regression for glyph_row_colour_expand
// Sends glyph rows through the valid/ready input; framebuffer writes are
// predicted from a shadow copy of the registers or given by hand. Each
// write leaving the block is checked field by field, in order. A short table of
// directed rows (wrapping coordinates, every depth, zero and oversized glyph
// widths) is followed by random rows under several register settings, with
// random gaps and stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import grce_pkg::*;

    localparam int unsigned SETTLE_CYCLES   = 6;
    localparam int unsigned LONG_HOLD       = 300;
    localparam int unsigned WATCHDOG_LIMIT  = 3000;
    localparam int unsigned NUM_PHASES      = 8;
    localparam int unsigned ROWS_PER_PHASE  = 32;

    typedef struct {
        bit          is_cfg;
        cfg_reg_t    creg;
        logic [31:0] cval;
        in_item_t    row;
        bit          typed;
        bit          one_write;
        out_item_t   wr;
    } dir_step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;
    logic        cfg_we = 1'b0;
    cfg_reg_t    cfg_index = CFG_FB_BASE;
    logic [31:0] cfg_data = '0;

    // shadow registers, reset values
    logic [31:0] fb_base_q = 32'd0;
    logic [15:0] pitch_q   = 16'd4096;
    depth_t      depth_q   = DEPTH_32;
    logic [5:0]  width_q   = 6'd8;

    out_item_t   pending_writes[$];
    dir_step_t   dir_steps[$];
    int unsigned faults = 0;
    int unsigned quiet_cycles = 0;
    bit          no_idle = 1'b0;
    bit          squeeze = 1'b0;

    glyph_row_colour_expand DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // expected writes for one row under the current register settings
    function automatic void expand_row(in_item_t r);
        int unsigned cols;
        int unsigned bitpos;
        logic [31:0] bytes;
        logic [31:0] mask;
        logic [3:0]  lanes;
        logic [15:0] y;
        logic [15:0] x;
        logic [31:0] line;
        out_item_t   w;
        bit          have;
        cols = (width_q > 6'd32) ? 32 : width_q;
        case (depth_q)
            DEPTH_8:  begin bytes = 1; mask = 32'h0000_00ff; lanes = 4'h1; end
            DEPTH_16: begin bytes = 2; mask = 32'h0000_ffff; lanes = 4'h3; end
            DEPTH_24: begin bytes = 3; mask = 32'h00ff_ffff; lanes = 4'h7; end
            default:  begin bytes = 4; mask = 32'hffff_ffff; lanes = 4'hf; end
        endcase
        y = r.pos_y + {11'd0, r.row_index};
        line = fb_base_q + {16'd0, pitch_q} * {16'd0, y};
        have = 1'b0;
        w = '0;
        for (int unsigned col = 0; col < cols; col++)
        begin
            bitpos = cols - 1 - col;
            if (r.glyph_bits[bitpos])
            begin
                if (have)
                    pending_writes.push_back(w);
                x = r.pos_x + 16'(col);
                w.write_address = line + bytes * {16'd0, x};
                w.write_data    = r.colour & mask;
                w.byte_enable   = lanes;
                w.last_write    = 1'b0;
                have = 1'b1;
            end
        end
        if (have)
        begin
            w.last_write = 1'b1;
            pending_writes.push_back(w);
        end
    endfunction

    function automatic void check_write(out_item_t got);
        out_item_t want;
        if (pending_writes.size() == 0)
        begin
            $error("write to %h with none expected", got.write_address);
            faults++;
            return;
        end
        want = pending_writes.pop_front();
        if (got.write_address !== want.write_address)
        begin
            $error("write_address: expected %h, got %h", want.write_address,
                   got.write_address);
            faults++;
        end
        if (got.write_data !== want.write_data)
        begin
            $error("write_data: expected %h, got %h", want.write_data, got.write_data);
            faults++;
        end
        if (got.byte_enable !== want.byte_enable)
        begin
            $error("byte_enable: expected %h, got %h", want.byte_enable,
                   got.byte_enable);
            faults++;
        end
        if (got.last_write !== want.last_write)
        begin
            $error("last_write: expected %b, got %b", want.last_write, got.last_write);
            faults++;
        end
    endfunction

    function automatic dir_step_t cfg_step(cfg_reg_t k, logic [31:0] v);
        dir_step_t s;
        s = '{is_cfg: 1'b0, creg: CFG_FB_BASE, cval: '0, row: '0,
              typed: 1'b0, one_write: 1'b0, wr: '0};
        s.is_cfg = 1'b1;
        s.creg   = k;
        s.cval   = v;
        return s;
    endfunction

    function automatic dir_step_t row_step(logic [31:0] b, logic [15:0] x,
                                           logic [15:0] y, logic [4:0] ri,
                                           logic [31:0] c);
        dir_step_t s;
        s = '{is_cfg: 1'b0, creg: CFG_FB_BASE, cval: '0, row: '0,
              typed: 1'b0, one_write: 1'b0, wr: '0};
        s.creg = CFG_FB_BASE;
        s.row.glyph_bits = b;
        s.row.pos_x      = x;
        s.row.pos_y      = y;
        s.row.row_index  = ri;
        s.row.colour     = c;
        return s;
    endfunction

    // row whose outcome is written out by hand: no write, or exactly one
    function automatic dir_step_t fixed_step(logic [31:0] b, logic [15:0] x,
                                             logic [15:0] y, logic [4:0] ri,
                                             logic [31:0] c, bit one,
                                             logic [31:0] addr, logic [31:0] data,
                                             logic [3:0] be);
        dir_step_t s;
        s = row_step(b, x, y, ri, c);
        s.typed     = 1'b1;
        s.one_write = one;
        s.wr.write_address = addr;
        s.wr.write_data    = data;
        s.wr.byte_enable   = be;
        s.wr.last_write    = 1'b1;
        return s;
    endfunction

    function automatic in_item_t random_row();
        in_item_t r;
        case ($urandom_range(0, 9))
            0:       r.glyph_bits = 32'd0;
            1:       r.glyph_bits = 32'hffff_ffff;
            2:       r.glyph_bits = 32'd1 << $urandom_range(0, 31);
            default: r.glyph_bits = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0:       r.pos_x = 16'hffff - 16'($urandom_range(0, 40));
            1:       r.pos_x = 16'd0;
            default: r.pos_x = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       r.pos_y = 16'hffff - 16'($urandom_range(0, 40));
            1:       r.pos_y = 16'd0;
            default: r.pos_y = 16'($urandom);
        endcase
        r.row_index = 5'($urandom_range(0, 31));
        r.colour    = $urandom;
        return r;
    endfunction

    task automatic cfg_write(cfg_reg_t k, logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= k;
        cfg_data  <= v;
        @(posedge clk);
        case (k)
            CFG_FB_BASE:    fb_base_q = v;
            CFG_LINE_PITCH: pitch_q   = v[15:0];
            CFG_DEPTH_MODE: depth_q   = depth_t'(v[1:0]);
            default:        width_q   = v[5:0];
        endcase
    endtask

    // let every expected write out, then give an empty row time to finish
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_row(in_item_t r, bit predict);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= r;
        do @(posedge clk); while (!in_ready);
        if (predict)
            expand_row(r);
    endtask

    initial
    begin : write_sink
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            if (squeeze)
            begin
                stall = LONG_HOLD;
                squeeze = 1'b0;
            end
            else if (no_idle)
                stall = 0;
            else
                stall = $urandom_range(0, 10);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            check_write(out_item);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("glyph_row_colour_expand regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        dir_step_t   st;
        int unsigned rows;
        logic [31:0] v;

        // reset settings first, then each depth, zero and oversized widths
        dir_steps.push_back(fixed_step(32'h80, 0, 0, 0, 32'h1234_5678, 1,
                                       32'h0, 32'h1234_5678, 4'hf));
        dir_steps.push_back(fixed_step(32'h01, 0, 0, 0, 32'h1234_5678, 1,
                                       32'h1c, 32'h1234_5678, 4'hf));
        dir_steps.push_back(fixed_step(32'h0, 0, 0, 0, 32'h1, 0, 0, 0, 0));
        // bits above the glyph width are ignored
        dir_steps.push_back(fixed_step(32'hffff_ff00, 5, 5, 5, 32'h1, 0, 0, 0, 0));
        dir_steps.push_back(fixed_step(32'h80, 16'hffff, 0, 0, 32'hdead_beef, 1,
                                       32'h0003_fffc, 32'hdead_beef, 4'hf));
        // y wraps back to scanline 0
        dir_steps.push_back(fixed_step(32'h80, 0, 16'hffff, 1, 32'hffff_ffff, 1,
                                       32'h0, 32'hffff_ffff, 4'hf));
        dir_steps.push_back(fixed_step(32'h80, 0, 16'hffff, 0, 32'h0, 1,
                                       32'h0fff_f000, 32'h0, 4'hf));
        dir_steps.push_back(row_step(32'hff, 16'hffff, 16'hffff, 31, 32'hffff_ffff));
        dir_steps.push_back(row_step(32'ha5, 100, 200, 5, 32'h0bad_f00d));
        dir_steps.push_back(cfg_step(CFG_DEPTH_MODE, DEPTH_8));
        dir_steps.push_back(cfg_step(CFG_FB_BASE, 32'hffff_ffff));
        // address wraps at 32 bits
        dir_steps.push_back(fixed_step(32'h80, 1, 0, 0, 32'haabb_ccdd, 1,
                                       32'h0, 32'h0000_00dd, 4'h1));
        dir_steps.push_back(row_step(32'hff, 16'hfffc, 0, 0, 32'h55aa_55aa));
        dir_steps.push_back(cfg_step(CFG_DEPTH_MODE, DEPTH_16));
        dir_steps.push_back(cfg_step(CFG_LINE_PITCH, 32'hffff));
        dir_steps.push_back(fixed_step(32'h80, 0, 1, 0, 32'h1234_5678, 1,
                                       32'h0000_fffe, 32'h0000_5678, 4'h3));
        dir_steps.push_back(row_step(32'h3c, 16'h7fff, 16'h1234, 17, 32'hfedc_ba98));
        dir_steps.push_back(cfg_step(CFG_DEPTH_MODE, DEPTH_24));
        dir_steps.push_back(cfg_step(CFG_LINE_PITCH, 32'h0));
        dir_steps.push_back(cfg_step(CFG_FB_BASE, 32'h1000));
        // 24 bpp leaves the top lane alone
        dir_steps.push_back(fixed_step(32'h80, 2, 99, 3, 32'haabb_ccdd, 1,
                                       32'h1006, 32'h00bb_ccdd, 4'h7));
        dir_steps.push_back(row_step(32'hff, 16'hffff, 16'h0042, 9, 32'h8765_4321));
        dir_steps.push_back(cfg_step(CFG_GLYPH_WIDTH, 32'd0));
        dir_steps.push_back(fixed_step(32'hffff_ffff, 0, 0, 0, 32'h1, 0, 0, 0, 0));
        dir_steps.push_back(cfg_step(CFG_GLYPH_WIDTH, 32'd32));
        dir_steps.push_back(cfg_step(CFG_DEPTH_MODE, DEPTH_32));
        dir_steps.push_back(cfg_step(CFG_LINE_PITCH, 32'd4096));
        dir_steps.push_back(cfg_step(CFG_FB_BASE, 32'h0));
        dir_steps.push_back(fixed_step(32'h8000_0000, 0, 0, 0, 32'h1, 1,
                                       32'h0, 32'h1, 4'hf));
        dir_steps.push_back(row_step(32'hffff_ffff, 16'hfff0, 5, 2, 32'h1357_9bdf));
        // oversized widths saturate to the bitmap width
        dir_steps.push_back(cfg_step(CFG_GLYPH_WIDTH, 32'd63));
        dir_steps.push_back(row_step(32'hffff_ffff, 7, 7, 7, 32'h2468_ace0));
        dir_steps.push_back(fixed_step(32'h1, 0, 0, 0, 32'ha5, 1,
                                       32'h7c, 32'ha5, 4'hf));
        dir_steps.push_back(cfg_step(CFG_GLYPH_WIDTH, 32'd33));
        dir_steps.push_back(row_step(32'h8000_0001, 300, 400, 30, 32'h0f0f_0f0f));
        dir_steps.push_back(cfg_step(CFG_GLYPH_WIDTH, 32'd1));
        dir_steps.push_back(fixed_step(32'hffff_fffe, 0, 0, 0, 32'h1, 0, 0, 0, 0));
        dir_steps.push_back(fixed_step(32'h1, 7, 0, 0, 32'h600d_cafe, 1,
                                       32'h1c, 32'h600d_cafe, 4'hf));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_steps[i])
        begin
            st = dir_steps[i];
            if (st.is_cfg)
            begin
                settle();
                cfg_write(st.creg, st.cval);
                cfg_we <= 1'b0;
            end
            else
            begin
                if (st.typed && st.one_write)
                    pending_writes.push_back(st.wr);
                send_row(st.row, !st.typed);
            end
        end

        for (int unsigned p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            case ($urandom_range(0, 2))
                0:       v = 32'h0;
                1:       v = 32'hffff_ffff;
                default: v = $urandom;
            endcase
            cfg_write(CFG_FB_BASE, v);
            v = $urandom;
            case ($urandom_range(0, 3))
                0:       v[15:0] = 16'h0;
                1:       v[15:0] = 16'hffff;
                2:       v[15:0] = 16'd2560;
                default: ;
            endcase
            cfg_write(CFG_LINE_PITCH, v);
            v = $urandom;
            cfg_write(CFG_DEPTH_MODE, v);
            v = $urandom;
            if (p == 0)
                v[5:0] = 6'd8;
            else
                case ($urandom_range(0, 7))
                    0:       v[5:0] = 6'd0;
                    1:       v[5:0] = 6'd32;
                    2:       v[5:0] = 6'($urandom_range(33, 63));
                    3:       v[5:0] = 6'd1;
                    default: v[5:0] = 6'($urandom_range(2, 16));
                endcase
            cfg_write(CFG_GLYPH_WIDTH, v);
            cfg_we <= 1'b0;
            no_idle = (p == 3 || p == 6);
            rows = (p == 0) ? ROWS_PER_PHASE + 8 : ROWS_PER_PHASE;
            for (int unsigned i = 0; i < rows; i++)
            begin
                // long receiver hold-off while rows keep coming
                if (p == 0 && i == 8)
                    squeeze = 1'b1;
                send_row(random_row(), 1'b1);
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (faults == 0 && pending_writes.size() == 0)
            $display("glyph_row_colour_expand regression: pass");
        else
            $display("glyph_row_colour_expand regression: fail");
        $finish;
    end

endmodule
